### rtl/core/image_flip_rotate_reorder_macros.svh
// Assertion macros shared by the frame reorienter RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef IMAGE_FLIP_ROTATE_REORDER_MACROS_SVH
`define IMAGE_FLIP_ROTATE_REORDER_MACROS_SVH

// The property must hold at every sampled clock edge.
`define IFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The antecedent implies the consequent at the next sampled clock edge.
`define IFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ifr_pkg.sv
`default_nettype none

package ifr_pkg;

  // Configuration port.
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Pixel word layout: pixel bytes in the low bits, alpha on top.
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned WORD_W  = PIX_W + ALPHA_W;
  localparam int unsigned BYTE_W  = 8;

  // Default frame limits.
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Register reset values.
  localparam logic [CFG_W-1:0] SRC_DIM_RST  = CFG_W'(256);
  localparam logic [1:0]       PIX_BYTES_RST = 2'd3;
  localparam logic [1:0]       PIX_BYTES_ONE = 2'd1;

  // Item kind carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    MODE_FLIP_H  = 2'd0,
    MODE_FLIP_V  = 2'd1,
    MODE_ROT_CW  = 2'd2,
    MODE_ROT_CCW = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_SRC_WIDTH   = 2'd1,
    REG_SRC_HEIGHT  = 2'd2,
    REG_PIXEL_BYTES = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

### rtl/core/image_flip_rotate_reorder.sv
// A read pixel reaches the master side through the memory read register and then the output
// register, which it enters once that register is free; writes give no result.
// Throughput: one beat per cycle; tready is low during a config write and the cycle after it,
// and otherwise stalls only when a read result waits behind a full output register.
// Reset: asynchronous active low; counters cleared, registers at their defaults,
// frame memory contents undefined and not cleared (no clearing pass).
`default_nettype none

`include "image_flip_rotate_reorder_macros.svh"

module image_flip_rotate_reorder #(
  parameter int unsigned MAX_WIDTH  = ifr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ifr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic [ifr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ifr_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Slave side: source pixel writes and destination pixel read requests.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: in_pixel [23:0], in_alpha [31:24]
  input  wire logic [ifr_pkg::WORD_W-1:0]          s_axis_tdata_i,
  // tuser: opcode [0]
  input  wire logic                                s_axis_tuser_i,
  // Master side: destination pixels in destination raster order.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: out_pixel [23:0], out_alpha [31:24]
  output logic [ifr_pkg::WORD_W-1:0]               m_axis_tdata_o,
  // tlast: frame_last
  output logic                                     m_axis_tlast_o
);

  import ifr_pkg::*;

  // Store geometry. The memory holds one full frame at the largest size.
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned TOT_W  = ADDR_W + 1;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);

  // Effective dimensions after reset: the default register value saturated to the maximum.
  localparam int unsigned RST_W     = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned RST_H     = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int unsigned RST_TOTAL = RST_W * RST_H;

  // ---------------------------------------------------------------------------
  // Configuration registers and the effective geometry derived from them.
  // Width and height are clamped to 1..MAX, and the frame size is computed once
  // per cycle into a register. tready is held low for the cycle that follows
  // a config write so that no beat ever sees the old geometry.
  // ---------------------------------------------------------------------------
  mode_e             mode_q;
  logic [CFG_W-1:0]  src_w_q, src_h_q;
  logic [1:0]        pix_bytes_q;
  logic              cfg_hold_q;

  logic [WW-1:0]     eff_w_d, eff_w_q;
  logic [HW-1:0]     eff_h_d, eff_h_q;
  logic [TOT_W-1:0]  total_d, total_q;

  always_comb begin
    if (src_w_q == '0) begin
      eff_w_d = WW'(1);
    end else if (32'(src_w_q) > 32'(MAX_WIDTH)) begin
      eff_w_d = WW'(MAX_WIDTH);
    end else begin
      eff_w_d = WW'(src_w_q);
    end
    if (src_h_q == '0) begin
      eff_h_d = HW'(1);
    end else if (32'(src_h_q) > 32'(MAX_HEIGHT)) begin
      eff_h_d = HW'(MAX_HEIGHT);
    end else begin
      eff_h_d = HW'(src_h_q);
    end
    total_d = TOT_W'(eff_w_d) * TOT_W'(eff_h_d);
  end

  // ---------------------------------------------------------------------------
  // Handshake. A read request that has its memory data in flight moves into
  // the output register when that register is free; while it cannot, no new
  // beat is taken so the registered read data stays put.
  // ---------------------------------------------------------------------------
  logic pend_q, pend_last_q;
  logic out_valid_q, out_last_q;
  logic [WORD_W-1:0] out_data_q;
  logic out_free, in_accept, wr_accept, rd_accept;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !cfg_we_i && !cfg_hold_q && (!pend_q || out_free);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_accept       = in_accept && (s_axis_tuser_i == OP_WRITE);
  assign rd_accept       = in_accept && (s_axis_tuser_i == OP_READ);

  // ---------------------------------------------------------------------------
  // Write side: source position counters and the destination address.
  // Every mode reduces to one multiply-add: row * stride + offset.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  wr_col_q, wr_col_d, col_cur;
  logic [ROW_W-1:0]  wr_row_q, wr_row_d, row_cur;
  logic [ADDR_W-1:0] x_ext, y_ext, w_ext, h_ext, xr_ext, yr_ext;
  logic [ADDR_W-1:0] mul_a, mul_b, add_c, wr_addr;
  logic [PIX_W-1:0]  wr_pix;
  logic [WORD_W-1:0] wr_word;

  always_comb begin
    // Counters past the current frame restart at the origin.
    if ((WW'(wr_col_q) >= eff_w_q) || (HW'(wr_row_q) >= eff_h_q)) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      col_cur = wr_col_q;
      row_cur = wr_row_q;
    end

    x_ext  = ADDR_W'(col_cur);
    y_ext  = ADDR_W'(row_cur);
    w_ext  = ADDR_W'(eff_w_q);
    h_ext  = ADDR_W'(eff_h_q);
    xr_ext = w_ext - ADDR_W'(1) - x_ext;   // mirrored column
    yr_ext = h_ext - ADDR_W'(1) - y_ext;   // mirrored row

    unique case (mode_q)
      MODE_FLIP_H: begin
        mul_a = y_ext;  mul_b = w_ext; add_c = xr_ext;
      end
      MODE_FLIP_V: begin
        mul_a = yr_ext; mul_b = w_ext; add_c = x_ext;
      end
      MODE_ROT_CW: begin
        mul_a = x_ext;  mul_b = h_ext; add_c = yr_ext;
      end
      MODE_ROT_CCW: begin
        mul_a = xr_ext; mul_b = h_ext; add_c = y_ext;
      end
      default: begin
        mul_a = y_ext;  mul_b = w_ext; add_c = xr_ext;
      end
    endcase
    wr_addr = ADDR_W'(mul_a * mul_b) + add_c;

    // Advance in source raster order.
    if ((WW'(col_cur) + WW'(1)) >= eff_w_q) begin
      wr_col_d = '0;
      if ((HW'(row_cur) + HW'(1)) >= eff_h_q) begin
        wr_row_d = '0;
      end else begin
        wr_row_d = row_cur + ROW_W'(1);
      end
    end else begin
      wr_col_d = col_cur + COL_W'(1);
      wr_row_d = row_cur;
    end

    // One-byte pixels keep only their low byte.
    if (pix_bytes_q == PIX_BYTES_ONE) begin
      wr_pix = {{(PIX_W-BYTE_W){1'b0}}, s_axis_tdata_i[BYTE_W-1:0]};
    end else begin
      wr_pix = s_axis_tdata_i[PIX_W-1:0];
    end
    wr_word = {s_axis_tdata_i[WORD_W-1:PIX_W], wr_pix};
  end

  // ---------------------------------------------------------------------------
  // Read side: linear destination index, wrapping after one frame.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d, rd_cur;
  logic              rd_last;

  always_comb begin
    rd_cur   = (TOT_W'(rd_idx_q) >= total_q) ? '0 : rd_idx_q;
    rd_last  = (TOT_W'(rd_cur) + TOT_W'(1)) == total_q;
    rd_idx_d = rd_last ? '0 : rd_cur + ADDR_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Frame memory. A write and a read never share a clock edge, and a read at a
  // later edge than a write to the same entry already sees the new word.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] ram_rdata;

  ifr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_accept),
    .waddr_i (wr_addr),
    .wdata_i (wr_word),
    .re_i    (rd_accept),
    .raddr_i (rd_cur),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control and state registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FLIP_H;
      src_w_q     <= SRC_DIM_RST;
      src_h_q     <= SRC_DIM_RST;
      pix_bytes_q <= PIX_BYTES_RST;
      cfg_hold_q  <= 1'b0;
      eff_w_q     <= WW'(RST_W);
      eff_h_q     <= HW'(RST_H);
      total_q     <= TOT_W'(RST_TOTAL);
      wr_col_q    <= '0;
      wr_row_q    <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      cfg_hold_q <= cfg_we_i;
      eff_w_q    <= eff_w_d;
      eff_h_q    <= eff_h_d;
      total_q    <= total_d;

      if (wr_accept) begin
        wr_col_q <= wr_col_d;
        wr_row_q <= wr_row_d;
      end
      if (rd_accept) begin
        rd_idx_q <= rd_idx_d;
      end

      // Config writes arrive only while no beat is taken.
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_MODE: begin
            mode_q <= mode_e'(cfg_wdata_i[1:0]);
          end
          REG_SRC_WIDTH: begin
            src_w_q  <= cfg_wdata_i;
            wr_col_q <= '0;
            wr_row_q <= '0;
            rd_idx_q <= '0;
          end
          REG_SRC_HEIGHT: begin
            src_h_q  <= cfg_wdata_i;
            wr_col_q <= '0;
            wr_row_q <= '0;
            rd_idx_q <= '0;
          end
          REG_PIXEL_BYTES: begin
            pix_bytes_q <= cfg_wdata_i[1:0];
          end
          default: begin
            pix_bytes_q <= pix_bytes_q;
          end
        endcase
      end

      // Read pipeline: memory stage, then output register.
      if (rd_accept) begin
        pend_q      <= 1'b1;
        pend_last_q <= rd_last;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
      end

      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        out_last_q  <= pend_last_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_data_q <= ram_rdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `IFR_ASSERT(a_rd_idx_in_frame, TOT_W'(rd_idx_q) < total_q,
              "read index left the frame")
  `IFR_ASSERT(a_wr_pos_in_frame, (WW'(wr_col_q) < eff_w_q) && (HW'(wr_row_q) < eff_h_q),
              "write position left the frame")
  `IFR_ASSERT(a_no_accept_on_stall, !(pend_q && !out_free && s_axis_tready_o),
              "beat taken while read data is stalled")
  `IFR_ASSERT_NEXT(a_pend_reaches_out, pend_q, out_valid_q,
                   "pending read did not reach the output register")
  `IFR_ASSERT_NEXT(a_cfg_blocks_next, cfg_we_i, !s_axis_tready_o,
                   "beat taken right after a config write")

endmodule

`default_nettype wire

### rtl/core/ifr_ram.sv
`default_nettype none

module ifr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sim/image_flip_rotate_reorder_tb.sv
`default_nettype none

module image_flip_rotate_reorder_tb;
  import ifr_pkg::*;

  // Frame geometry limits match the defaults that the block is built with.
  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam int STORE_WORDS = MAX_W * MAX_H;

  // A read shows up through the memory read register and the output register, and
  // tready drops during a register write and the cycle after it. Idle cycles before
  // each register write let any write beat still in the pipeline reach the frame memory.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BEATS  = 1450;

  // Each entry of the stimulus queue is a pixel beat, a register write, or a
  // pause in which the sender holds off until every owed pixel has arrived.
  typedef enum logic [1:0] {
    STEP_BEAT,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic        op;
    logic [23:0] pixel;
    logic [7:0]  alpha;
    cfg_reg_e    reg_idx;
    logic [8:0]  reg_val;
    int          gap;
    bit          has_pixel;
    logic [23:0] want_pixel;
    logic [7:0]  want_alpha;
    logic        want_last;
  } step_t;

  typedef struct {
    logic [23:0] pixel;
    logic [7:0]  alpha;
    logic        last;
  } dest_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  wire logic            s_tready;
  logic [WORD_W-1:0]    s_tdata = '0;
  logic                 s_tuser = 1'b0;
  wire logic            m_tvalid;
  logic                 m_tready = 1'b0;
  wire logic [WORD_W-1:0] m_tdata;
  wire logic            m_tlast;

  image_flip_rotate_reorder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    // tdata: in_pixel [23:0], in_alpha [31:24]
    .s_axis_tdata_i  (s_tdata),
    // tuser: opcode [0]
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // tdata: out_pixel [23:0], out_alpha [31:24]
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk = ~clk;

  // Stimulus in issue order, and destination pixels owed by accepted reads.
  step_t       pending_steps[$];
  dest_pixel_t owed_pixels[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  beats_queued = 0;
  bit  beat_taken = 1'b0;

  // ---------------------------------------------------------------------
  // Frame reorienter prediction. The generator runs it in issue order, so
  // its state always matches what the block will hold once the queued
  // steps have gone through. Every read beat carries its own expected pixel.
  // ---------------------------------------------------------------------
  mode_e       geo_mode = MODE_FLIP_H;
  logic [8:0]  geo_width = SRC_DIM_RST;
  logic [8:0]  geo_height = SRC_DIM_RST;
  logic [1:0]  geo_pix_bytes = PIX_BYTES_RST;
  int          wr_col = 0;
  int          wr_row = 0;
  int          rd_index = 0;
  logic [31:0] frame_mem [STORE_WORDS];
  // Marks destination words written since reset; reads only go to these.
  bit          frame_seen [STORE_WORDS];

  // Zero sizes count as one pixel and oversized ones saturate.
  function automatic int eff_dim(logic [8:0] v, int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic int dest_addr(int x, int y, int w, int h);
    case (geo_mode)
      MODE_FLIP_H: return y * w + (w - 1 - x);
      MODE_FLIP_V: return (h - 1 - y) * w + x;
      MODE_ROT_CW: return x * h + (h - 1 - y);
      default:     return (w - 1 - x) * h + y;
    endcase
  endfunction

  function automatic void reorient_write_reg(cfg_reg_e idx, logic [8:0] val);
    case (idx)
      REG_MODE: geo_mode = mode_e'(val[1:0]);
      REG_SRC_WIDTH: begin
        // Any geometry change restarts both the source and the read raster.
        geo_width = val;
        wr_col = 0;
        wr_row = 0;
        rd_index = 0;
      end
      REG_SRC_HEIGHT: begin
        geo_height = val;
        wr_col = 0;
        wr_row = 0;
        rd_index = 0;
      end
      default: geo_pix_bytes = val[1:0];
    endcase
  endfunction

  function automatic step_t reorient_step(step_t s);
    int          w;
    int          h;
    int          total;
    int          addr;
    logic [23:0] pix;
    logic [31:0] word;
    w = eff_dim(geo_width, MAX_W);
    h = eff_dim(geo_height, MAX_H);
    total = w * h;
    if (s.op == OP_WRITE) begin
      pix = s.pixel;
      // One-byte pixels keep only their low byte; any other size is RGB.
      if (geo_pix_bytes == PIX_BYTES_ONE) pix[23:8] = '0;
      if (wr_col >= w || wr_row >= h) begin
        wr_col = 0;
        wr_row = 0;
      end
      addr = dest_addr(wr_col, wr_row, w, h);
      frame_mem[addr] = {s.alpha, pix};
      frame_seen[addr] = 1'b1;
      if (wr_col + 1 >= w) begin
        wr_col = 0;
        wr_row = (wr_row + 1 >= h) ? 0 : wr_row + 1;
      end else begin
        wr_col++;
      end
      s.has_pixel = 1'b0;
    end else begin
      if (rd_index >= total) rd_index = 0;
      word = frame_mem[rd_index];
      s.want_pixel = word[23:0];
      s.want_alpha = word[31:24];
      s.want_last = (rd_index + 1 == total);
      rd_index = (rd_index + 1 >= total) ? 0 : rd_index + 1;
      s.has_pixel = 1'b1;
    end
    return s;
  endfunction

  // True when the next read lands on a destination word that holds data.
  function automatic bit next_read_valid();
    int total;
    total = eff_dim(geo_width, MAX_W) * eff_dim(geo_height, MAX_H);
    return frame_seen[(rd_index >= total) ? 0 : rd_index];
  endfunction

  // Pause lengths: mostly a few cycles, now and then a long one.
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    return pick_pause();
  endfunction

  // A step with every field at a neutral value.
  function automatic step_t blank_step();
    step_t s;
    s.kind       = STEP_BEAT;
    s.op         = OP_WRITE;
    s.pixel      = '0;
    s.alpha      = '0;
    s.reg_idx    = REG_MODE;
    s.reg_val    = '0;
    s.gap        = 0;
    s.has_pixel  = 1'b0;
    s.want_pixel = '0;
    s.want_alpha = '0;
    s.want_last  = 1'b0;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------
  task automatic queue_cfg(cfg_reg_e idx, logic [8:0] val);
    step_t s;
    s = blank_step();
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    reorient_write_reg(idx, val);
    pending_steps.push_back(s);
  endtask

  task automatic queue_beat(logic op, logic [23:0] pix, logic [7:0] alpha, int gap);
    step_t s;
    s = blank_step();
    s.kind = STEP_BEAT;
    s.op = op;
    s.pixel = pix;
    s.alpha = alpha;
    s.gap = gap;
    pending_steps.push_back(reorient_step(s));
    beats_queued++;
  endtask

  task automatic queue_drain();
    step_t s;
    s = blank_step();
    s.kind = STEP_DRAIN;
    pending_steps.push_back(s);
  endtask

  // Mixes source writes and destination reads in random order. A read is
  // only issued once its destination word has been written at some point.
  task automatic queue_frame_traffic(int n_wr, int n_rd, bit calm);
    int gap;
    while (n_wr > 0 || n_rd > 0) begin
      gap = calm ? 0 : pick_gap();
      if (n_rd > 0 && next_read_valid() && (n_wr == 0 || $urandom_range(0, 1) == 1)) begin
        queue_beat(OP_READ, 24'($urandom_range(0, 24'hFFFFFF)),
                   8'($urandom_range(0, 255)), gap);
        n_rd--;
      end else if (n_wr > 0) begin
        queue_beat(OP_WRITE, 24'($urandom_range(0, 24'hFFFFFF)),
                   8'($urandom_range(0, 255)), gap);
        n_wr--;
      end else begin
        n_rd = 0;
      end
      if ($urandom_range(0, 199) == 0) queue_drain();
    end
  endtask

  task automatic report_mismatch(string what, dest_pixel_t want, logic [31:0] data,
                                 logic last);
    mismatches++;
    if (mismatches <= 10) begin
      $write("mismatch at cycle %0d (%s): expected pixel %06h alpha %02h last %0b, ",
             cycle_count, what, want.pixel, want.alpha, want.last);
      $display("got pixel %06h alpha %02h last %0b", data[23:0], data[31:24], last);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver. Runs on the falling edge so the block sees stable inputs at the
  // rising edge. The head of the queue stays on the bus until the sampling
  // block below sees it accepted and pops it.
  // ---------------------------------------------------------------------
  int sink_hold = 0;
  int sink_stall_pct = 20;
  int src_idle = 0;
  int settle = 0;

  always @(negedge clk) begin : drive_inputs
    step_t cur;
    logic  we;
    if (rst_n) begin
      we = 1'b0;

      // The receiver stalls at a rate that changes with each register write,
      // which gives stretches with no back pressure at all.
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        sink_hold = pick_pause() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end

      if (!s_tvalid || beat_taken) begin
        beat_taken = 1'b0;
        if (src_idle > 0) begin
          src_idle--;
          s_tvalid <= 1'b0;
        end else if (pending_steps.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur = pending_steps[0];
          case (cur.kind)
            STEP_CFG: begin
              // Registers change only once the block has gone quiet.
              s_tvalid <= 1'b0;
              if (owed_pixels.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE_CYCLES) begin
                settle++;
              end else begin
                we = 1'b1;
                cfg_index <= cur.reg_idx;
                cfg_wdata <= cur.reg_val;
                void'(pending_steps.pop_front());
                settle = 0;
                case ($urandom_range(0, 2))
                  0:       sink_stall_pct = 0;
                  1:       sink_stall_pct = 10;
                  default: sink_stall_pct = 40;
                endcase
              end
            end
            STEP_DRAIN: begin
              s_tvalid <= 1'b0;
              if (owed_pixels.size() == 0) void'(pending_steps.pop_front());
            end
            default: begin
              s_tvalid <= 1'b1;
              s_tdata  <= {cur.alpha, cur.pixel};
              s_tuser  <= cur.op;
              src_idle = cur.gap;
            end
          endcase
        end
      end
      cfg_we <= we;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. Samples on the rising edge: first the master side against the
  // oldest owed pixel, then the slave side, whose accepted read only adds a
  // pixel to the owed queue after this edge's result has been checked.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : sample_outputs
    step_t       accepted;
    dest_pixel_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles with %0d pixels still owed",
                 cycle_count, owed_pixels.size());
        $display("== FAIL ==");
        $finish;
      end

      if (m_tvalid && m_tready) begin
        if (owed_pixels.size() == 0) begin
          want = '{default: '0};
          report_mismatch("no pixel owed", want, m_tdata, m_tlast);
        end else begin
          want = owed_pixels.pop_front();
          if (m_tdata[23:0] !== want.pixel || m_tdata[31:24] !== want.alpha ||
              m_tlast !== want.last)
            report_mismatch("wrong pixel", want, m_tdata, m_tlast);
        end
      end

      if (s_tvalid && s_tready) begin
        accepted = pending_steps.pop_front();
        if (accepted.has_pixel)
          owed_pixels.push_back('{accepted.want_pixel, accepted.want_alpha,
                                  accepted.want_last});
        beat_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------
  initial begin : run_plan
    int w;
    int h;
    int n_wr;
    int n_rd;

    // Directed part: a 2x2 frame with extreme pixel and alpha values.
    queue_cfg(REG_MODE, 9'(MODE_FLIP_H));
    queue_cfg(REG_SRC_WIDTH, 9'd2);
    queue_cfg(REG_SRC_HEIGHT, 9'd2);
    queue_cfg(REG_PIXEL_BYTES, 9'd3);
    queue_beat(OP_WRITE, 24'h000000, 8'h00, 0);
    queue_beat(OP_WRITE, 24'hFFFFFF, 8'hFF, 0);
    queue_beat(OP_WRITE, 24'hA55AC3, 8'h3C, 0);
    queue_beat(OP_WRITE, 24'h5AA53C, 8'hC3, 0);
    repeat (4) queue_beat(OP_READ, 24'hFFFFFF, 8'hFF, 0);
    queue_drain();

    // One-byte pixels drop the upper bytes; the mode then changes mid frame.
    queue_cfg(REG_PIXEL_BYTES, 9'(PIX_BYTES_ONE));
    queue_beat(OP_WRITE, 24'hFFFFFF, 8'hFF, 0);
    queue_beat(OP_WRITE, 24'h12345E, 8'h81, 1);
    queue_cfg(REG_MODE, 9'(MODE_ROT_CW));
    queue_beat(OP_WRITE, 24'hFFFF01, 8'h00, 0);
    queue_beat(OP_WRITE, 24'hFEDC7F, 8'h7F, 2);
    repeat (4) queue_beat(OP_READ, 24'h000000, 8'h00, 0);

    // Zero width counts as one column, and pixel size 2 counts as RGB.
    queue_cfg(REG_SRC_WIDTH, 9'd0);
    queue_cfg(REG_SRC_HEIGHT, 9'd3);
    queue_cfg(REG_PIXEL_BYTES, 9'd2);
    queue_cfg(REG_MODE, 9'(MODE_FLIP_V));
    repeat (3) queue_beat(OP_WRITE, 24'($urandom_range(0, 24'hFFFFFF)),
                          8'($urandom_range(0, 255)), 0);
    repeat (3) queue_beat(OP_READ, 24'($urandom_range(0, 24'hFFFFFF)),
                          8'($urandom_range(0, 255)), 0);

    // Widest frame, one row high, written and read in full.
    queue_cfg(REG_MODE, 9'($urandom_range(0, 3)));
    queue_cfg(REG_SRC_WIDTH, 9'd256);
    queue_cfg(REG_SRC_HEIGHT, 9'd1);
    queue_cfg(REG_PIXEL_BYTES, 9'($urandom_range(0, 3)));
    queue_frame_traffic(256, 256, 1'b0);

    // Oversized height saturates to the tallest frame, one column wide.
    queue_cfg(REG_MODE, 9'($urandom_range(0, 3)));
    queue_cfg(REG_SRC_WIDTH, 9'd1);
    queue_cfg(REG_SRC_HEIGHT, 9'd511);
    queue_frame_traffic(256, 64, 1'b1);

    // Random part: small frames, most of them written and read in full, some
    // cut short, and some that carry on across a mode change.
    while (beats_queued < RANDOM_BEATS) begin
      queue_cfg(REG_MODE, 9'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) begin
        queue_cfg(REG_SRC_WIDTH, 9'($urandom_range(0, 10)));
        queue_cfg(REG_SRC_HEIGHT, 9'($urandom_range(0, 10)));
      end
      queue_cfg(REG_PIXEL_BYTES, 9'($urandom_range(0, 3)));
      w = eff_dim(geo_width, MAX_W);
      h = eff_dim(geo_height, MAX_H);
      n_wr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h) : w * h;
      n_rd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, w * h) : w * h;
      queue_frame_traffic(n_wr, n_rd, $urandom_range(0, 3) == 0);
    end

    // Reset is held low from the start and released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_steps.size() != 0 || owed_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
